// File: rtl/zcps_pkg.sv
// Shared types, constants and register map of the zero-current phase switch sequencer.
package zcps_pkg;

  localparam logic [7:0] RAMPDOWN_RESET = 8'd50;
  localparam logic [7:0] SETTLE_RESET   = 8'd5;
  localparam logic [7:0] RETRIES_RESET  = 8'd3;
  localparam logic [7:0] COUNT_MAX      = 8'd255;

  localparam logic [1:0] PHASE_SINGLE = 2'd1;
  localparam logic [1:0] PHASE_THREE  = 2'd3;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_RAMPDOWN = 2'd0;
  localparam logic [1:0] REG_SETTLE   = 2'd1;
  localparam logic [1:0] REG_RETRIES  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_CAR_STOP = 2'd1,
    ST_SETTLE   = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic [7:0] rampdown_ticks;
    logic [7:0] settle_ticks;
    logic [7:0] max_relay_retries;
  } cfg_t;

  typedef struct packed {
    logic       relay_ack;
    logic       pwm_ack;
    logic [7:0] target_current;
    logic [1:0] requested_phases;
  } item_t;

  typedef struct packed {
    logic [1:0] held_phases;
    logic [1:0] seq_state;
    logic [7:0] failure_count;
    logic       hw_fault;
    logic [1:0] relay_phases;
    logic       relay_write;
    logic [7:0] pwm_current;
    logic       pwm_write;
  } result_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
  endfunction

endpackage

// File: rtl/zcps_cfg.sv
// APB register block holding ramp-down, settle and retry limits.
module zcps_cfg
  import zcps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rampdown_ticks    <= RAMPDOWN_RESET;
      cfg.settle_ticks      <= SETTLE_RESET;
      cfg.max_relay_retries <= RETRIES_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RAMPDOWN: cfg.rampdown_ticks    <= pwdata[7:0];
        REG_SETTLE:   cfg.settle_ticks      <= pwdata[7:0];
        REG_RETRIES:  cfg.max_relay_retries <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RAMPDOWN: prdata = {24'd0, cfg.rampdown_ticks};
      REG_SETTLE:   prdata = {24'd0, cfg.settle_ticks};
      REG_RETRIES:  prdata = {24'd0, cfg.max_relay_retries};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/zcps_seq.sv
// Sequencer state registers and the per-tick update and result logic.
module zcps_seq
  import zcps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  seq_state_t state, state_next;
  logic [1:0] relay_mode, relay_mode_next;
  logic [1:0] pending_mode, pending_mode_next;
  logic [7:0] wait_timer, wait_timer_next;
  logic [7:0] retry_count, retry_count_next;
  logic       fault, fault_next;
  logic [7:0] failures, failures_next;

  logic [7:0] timer_inc;
  logic [7:0] retry_inc;
  logic       change;
  logic       ramp_done;
  logic       settle_done;

  assign timer_inc   = sat_inc(wait_timer);
  assign retry_inc   = sat_inc(retry_count);
  assign ramp_done   = timer_inc >= cfg.rampdown_ticks;
  assign settle_done = timer_inc >= cfg.settle_ticks;
  assign change      = (item.requested_phases == PHASE_SINGLE ||
                        item.requested_phases == PHASE_THREE) &&
                       (item.requested_phases != relay_mode);

  always_comb begin
    state_next = state;
    case (state)
      ST_CAR_STOP: begin
        if (ramp_done && item.relay_ack) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (settle_done) state_next = ST_IDLE;
      end
      default: begin
        state_next = (item.pwm_ack && change) ? ST_CAR_STOP : ST_IDLE;
      end
    endcase
  end

  always_comb begin
    relay_mode_next   = relay_mode;
    pending_mode_next = pending_mode;
    wait_timer_next   = wait_timer;
    retry_count_next  = retry_count;
    fault_next        = fault;
    failures_next     = failures;
    res               = '0;
    case (state)
      ST_CAR_STOP: begin
        wait_timer_next = timer_inc;
        if (ramp_done) begin
          res.relay_write  = 1'b1;
          res.relay_phases = pending_mode;
          if (item.relay_ack) begin
            relay_mode_next = pending_mode;
            wait_timer_next = 8'd0;
            fault_next      = 1'b0;
            failures_next   = 8'd0;
          end else begin
            failures_next    = sat_inc(failures);
            retry_count_next = retry_inc;
            if (retry_inc >= cfg.max_relay_retries) fault_next = 1'b1;
          end
        end
      end
      ST_SETTLE: begin
        wait_timer_next = timer_inc;
        if (settle_done) retry_count_next = 8'd0;
      end
      default: begin
        res.pwm_write   = 1'b1;
        res.pwm_current = change ? 8'd0 : item.target_current;
        if (item.pwm_ack) begin
          if (change) begin
            wait_timer_next   = 8'd0;
            pending_mode_next = item.requested_phases;
          end
          retry_count_next = 8'd0;
          fault_next       = 1'b0;
          failures_next    = 8'd0;
        end else begin
          fault_next    = 1'b1;
          failures_next = sat_inc(failures);
        end
      end
    endcase
    res.hw_fault      = fault_next;
    res.failure_count = failures_next;
    res.seq_state     = state_next;
    res.held_phases   = relay_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      relay_mode   <= PHASE_SINGLE;
      pending_mode <= PHASE_SINGLE;
      wait_timer   <= 8'd0;
      retry_count  <= 8'd0;
      fault        <= 1'b0;
      failures     <= 8'd0;
    end else if (step) begin
      state        <= state_next;
      relay_mode   <= relay_mode_next;
      pending_mode <= pending_mode_next;
      wait_timer   <= wait_timer_next;
      retry_count  <= retry_count_next;
      fault        <= fault_next;
      failures     <= failures_next;
    end
  end

endmodule

// File: rtl/zero_current_phase_switch_sequencer.sv
// Top level: input register, sequencer step, result register and APB registers.
// Path: a word is held in the input register, then its result in the output register.
// Throughput: one word per cycle unless m_axis_tready holds the output back.
// Reset: synchronous rst empties both registers, returns the sequencer to idle on
// single phase with cleared counters and fault, and loads the register defaults.
module zero_current_phase_switch_sequencer
  import zcps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] requested_phases, [9:2] target_current, [10] pwm_ack, [11] relay_ack
  input  logic [15:0]       s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] pwm_write, [8:1] pwm_current, [9] relay_write, [11:10] relay_phases,
  // [12] hw_fault, [20:13] failure_count, [22:21] seq_state, [24:23] held_phases
  output logic [31:0]       m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata[11:0]);
    end
  end

  zcps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zcps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {7'd0, res};
    end
  end

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
    else $error("current and relay command in one word");

  a_relay_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[9]) |->
      (m_axis_tdata[11:10] == PHASE_SINGLE || m_axis_tdata[11:10] == PHASE_THREE))
    else $error("relay command without a valid phase mode");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && in_valid) |-> !s_axis_tready)
    else $error("input taken while both stages are held");

endmodule
